FILE: rtl/core/msp_pkg.sv
// shared constants, types and helpers for the multi-stack shared node pool
// no dependencies; every other file of the block uses it by scoped names
package msp_pkg;

    localparam int MAX_STACKS = 1024;
    localparam int POOL_NODES = 4096;

    localparam int IDX_W   = 10;
    localparam int VAL_W   = 32;
    localparam int CMD_W   = 2;
    localparam int CNT_W   = 11;
    localparam int STAT_W  = 2;
    localparam int STACK_W = $clog2(MAX_STACKS);
    localparam int NODE_W  = $clog2(POOL_NODES + 1);
    localparam int ADDR_W  = $clog2(POOL_NODES);

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

    localparam logic [CNT_W-1:0]  STACKS_RESET = CNT_W'(1024);
    localparam logic [NODE_W-1:0] NULL_NODE    = NODE_W'(POOL_NODES);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_TOP  = 2'd1,
        CMD_POP  = 2'd2,
        CMD_RSVD = 2'd3
    } t_command;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_BADIDX = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        K_PUSH,
        K_TOP,
        K_POP,
        K_NOP,
        K_BAD
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [IDX_W-1:0]         stack_index;
        logic signed [VAL_W-1:0]  push_value;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic logic node_ok(input logic [NODE_W-1:0] n);
        return n < NULL_NODE;
    endfunction

endpackage

FILE: rtl/core/msp_in_if.sv
// command channel: valid/ready with command, stack index and push value
// depends on msp_pkg for field widths
interface msp_in_if;
    logic                             valid;
    logic                             ready;
    logic [msp_pkg::CMD_W-1:0]        command;
    logic [msp_pkg::IDX_W-1:0]        stack_index;
    logic signed [msp_pkg::VAL_W-1:0] push_value;

    modport source (output valid, output command, output stack_index,
                    output push_value, input ready);
    modport sink   (input valid, input command, input stack_index,
                    input push_value, output ready);
endinterface

FILE: rtl/core/msp_out_if.sv
// result channel: valid/ready with top value and status
// depends on msp_pkg for field widths
interface msp_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [msp_pkg::VAL_W-1:0] top_value;
    logic [msp_pkg::STAT_W-1:0]       status;

    modport source (output valid, output top_value, output status, input ready);
    modport sink   (input valid, input top_value, input status, output ready);
endinterface

FILE: rtl/core/msp_cfg_if.sv
// configuration write channel: valid/ready with the stacks_in_use value
// depends on msp_pkg for the data width
interface msp_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [msp_pkg::CNT_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/multi_stack_shared_pool_top.sv
// push, bad-index, unknown and empty-stack commands are answered from the EXEC state; top and
// pop on a non-empty stack go on to the FIN state, after the dependent head-table then
// node-pool reads. the engine takes one command at a time (IDLE, EXEC, FIN) and holds in
// EXEC or FIN while the result register is not free. a 2-entry command queue lets the front
// accept while the engine works.
// reset: synchronous active low; afterwards a clearing pass writes every entry of the
// 1024-entry head table, during which no command transaction is accepted
module multi_stack_shared_pool_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    msp_in_if.sink      i_cmd,
    msp_cfg_if.sink     i_cfg,
    msp_out_if.source   o_res
);

    // front to queue
    logic                 w_push;
    msp_pkg::t_cmd        w_front_item;

    // queue to engine
    logic                 w_pop;
    msp_pkg::t_cmd        w_queue_item;
    msp_pkg::t_fifo_stat  w_fifo;

    // engine status back to the front
    logic                 w_clearing;

    // accepts commands, range-checks the stack index against stacks_in_use
    msp_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (i_cmd),
        .i_cfg      (i_cfg),
        .i_fifo     (w_fifo),
        .i_clearing (w_clearing),
        .o_push     (w_push),
        .o_item     (w_front_item)
    );

    // decouples acceptance from execution
    msp_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .i_pop   (w_pop),
        .o_item  (w_queue_item),
        .o_stat  (w_fifo)
    );

    // head table, node pool, free list and result register
    msp_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (w_queue_item),
        .i_fifo     (w_fifo),
        .o_pop      (w_pop),
        .o_clearing (w_clearing),
        .o_res      (o_res)
    );

    // no command transaction while the head table is being cleared
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !(i_cmd.valid && i_cmd.ready))
        else $error("command accepted during clearing pass");

    // a non-zero top value only comes with an ok status
    a_value_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.top_value != 0) |-> (o_res.status == msp_pkg::ST_OK))
        else $error("non-zero top value with a failing status");

    // the queue is never written while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_fifo.full)
        else $error("command queue overflow");

    // the engine never pulls from an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_fifo.empty)
        else $error("command queue underflow");

endmodule

FILE: rtl/core/msp_front.sv
// front end: holds stacks_in_use, accepts commands and classifies them
// depends on msp_pkg, msp_in_if and msp_cfg_if
module msp_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    msp_in_if.sink               i_cmd,
    msp_cfg_if.sink              i_cfg,
    input  msp_pkg::t_fifo_stat  i_fifo,
    input  logic                 i_clearing,
    output logic                 o_push,
    output msp_pkg::t_cmd        o_item
);

    logic [msp_pkg::CNT_W-1:0] r_stacks_in_use;
    logic                      bad_index;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stacks_in_use <= msp_pkg::STACKS_RESET;
        end else if (i_cfg.valid) begin
            r_stacks_in_use <= i_cfg.data;
        end
    end

    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = !i_fifo.full && !i_clearing;
    assign o_push      = i_cmd.valid && i_cmd.ready;

    assign bad_index = (msp_pkg::CNT_W'(i_cmd.stack_index) >= r_stacks_in_use)
                    || (int'(i_cmd.stack_index) >= msp_pkg::MAX_STACKS);

    always_comb begin
        o_item.stack_index = i_cmd.stack_index;
        o_item.push_value  = i_cmd.push_value;
        if (bad_index) begin
            o_item.kind = msp_pkg::K_BAD;
        end else begin
            case (msp_pkg::t_command'(i_cmd.command))
                msp_pkg::CMD_PUSH: o_item.kind = msp_pkg::K_PUSH;
                msp_pkg::CMD_TOP:  o_item.kind = msp_pkg::K_TOP;
                msp_pkg::CMD_POP:  o_item.kind = msp_pkg::K_POP;
                default:           o_item.kind = msp_pkg::K_NOP;
            endcase
        end
    end

endmodule

FILE: rtl/core/msp_fifo.sv
// short command queue between the front end and the execution engine
// depends on msp_pkg for the item type and depth
module msp_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  msp_pkg::t_cmd        i_item,
    input  logic                 i_pop,
    output msp_pkg::t_cmd        o_item,
    output msp_pkg::t_fifo_stat  o_stat
);

    localparam int CNT_BITS = msp_pkg::FIFO_PTR_W + 1;

    msp_pkg::t_cmd                  r_mem [msp_pkg::FIFO_DEPTH];
    logic [msp_pkg::FIFO_PTR_W-1:0] r_wr_ptr;
    logic [msp_pkg::FIFO_PTR_W-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0]            r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (int'(r_wr_ptr) == msp_pkg::FIFO_DEPTH - 1)
                          ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (int'(r_rd_ptr) == msp_pkg::FIFO_DEPTH - 1)
                          ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_item       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == CNT_BITS'(msp_pkg::FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);

endmodule

FILE: rtl/core/msp_back.sv
// execution engine: head table, node pool, free list and result register
// depends on msp_pkg and msp_out_if
module msp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  msp_pkg::t_cmd        i_item,
    input  msp_pkg::t_fifo_stat  i_fifo,
    output logic                 o_pop,
    output logic                 o_clearing,
    msp_out_if.source            o_res
);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC, S_FIN} t_state;

    // memories
    logic [msp_pkg::NODE_W-1:0]        m_head  [msp_pkg::MAX_STACKS];
    logic [msp_pkg::NODE_W-1:0]        m_below [msp_pkg::POOL_NODES];
    logic signed [msp_pkg::VAL_W-1:0]  m_value [msp_pkg::POOL_NODES];

    t_state                            r_state, n_state;
    msp_pkg::t_cmd                     r_item;
    logic [msp_pkg::STACK_W-1:0]       r_clr;
    logic [msp_pkg::NODE_W-1:0]        r_free, n_free;
    logic [msp_pkg::NODE_W-1:0]        r_fresh, n_fresh;
    logic [msp_pkg::NODE_W-1:0]        r_head_q;
    logic [msp_pkg::NODE_W-1:0]        r_link_q;
    logic signed [msp_pkg::VAL_W-1:0]  r_val_q;
    logic                              r_out_valid;
    logic signed [msp_pkg::VAL_W-1:0]  r_out_top, n_out_top;
    msp_pkg::t_status                  r_out_status, n_out_status;

    logic                              out_free;
    logic                              out_fire;
    logic                              go_fin;
    logic                              link_en;
    logic [msp_pkg::NODE_W-1:0]        new_node;
    logic                              pool_full;

    logic                              head_we;
    logic [msp_pkg::STACK_W-1:0]       head_wa;
    logic [msp_pkg::NODE_W-1:0]        head_wd;
    logic                              below_we;
    logic [msp_pkg::ADDR_W-1:0]        below_wa;
    logic [msp_pkg::NODE_W-1:0]        below_wd;
    logic                              value_we;
    logic [msp_pkg::ADDR_W-1:0]        below_ra;

    assign out_free   = !r_out_valid || o_res.ready;
    assign o_pop      = (r_state == S_IDLE) && !i_fifo.empty;
    assign o_clearing = (r_state == S_CLEAR);
    assign go_fin     = (r_state == S_EXEC)
                     && (r_item.kind == msp_pkg::K_TOP || r_item.kind == msp_pkg::K_POP)
                     && msp_pkg::node_ok(r_head_q);
    assign link_en    = o_pop || go_fin;
    assign below_ra   = o_pop ? r_free[msp_pkg::ADDR_W-1:0]
                              : r_head_q[msp_pkg::ADDR_W-1:0];

    // node for a push: free list first, then a never-used node
    always_comb begin
        pool_full = 1'b0;
        n_free    = r_free;
        n_fresh   = r_fresh;
        if (msp_pkg::node_ok(r_free)) begin
            new_node = r_free;
            n_free   = r_link_q;
        end else if (r_fresh < msp_pkg::NULL_NODE) begin
            new_node = r_fresh;
            n_fresh  = r_fresh + 1'b1;
        end else begin
            new_node  = msp_pkg::NULL_NODE;
            pool_full = 1'b1;
        end
    end

    always_comb begin
        n_state      = r_state;
        out_fire     = 1'b0;
        n_out_top    = '0;
        n_out_status = msp_pkg::ST_OK;
        head_we      = 1'b0;
        head_wa      = r_item.stack_index[msp_pkg::STACK_W-1:0];
        head_wd      = new_node;
        below_we     = 1'b0;
        below_wa     = new_node[msp_pkg::ADDR_W-1:0];
        below_wd     = r_head_q;
        value_we     = 1'b0;
        case (r_state)
            S_CLEAR: begin
                head_we = 1'b1;
                head_wa = r_clr;
                head_wd = msp_pkg::NULL_NODE;
                if (int'(r_clr) == msp_pkg::MAX_STACKS - 1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (o_pop) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (go_fin) begin
                    n_state = S_FIN;
                end else if (out_free) begin
                    out_fire = 1'b1;
                    n_state  = S_IDLE;
                    case (r_item.kind)
                        msp_pkg::K_BAD:  n_out_status = msp_pkg::ST_BADIDX;
                        msp_pkg::K_PUSH: begin
                            if (pool_full) begin
                                n_out_status = msp_pkg::ST_FULL;
                            end else begin
                                head_we  = 1'b1;
                                below_we = 1'b1;
                                value_we = 1'b1;
                            end
                        end
                        msp_pkg::K_TOP,
                        msp_pkg::K_POP:  n_out_status = msp_pkg::ST_EMPTY;
                        default:         n_out_status = msp_pkg::ST_OK;
                    endcase
                end
            end
            S_FIN: begin
                if (out_free) begin
                    out_fire = 1'b1;
                    n_state  = S_IDLE;
                    if (r_item.kind == msp_pkg::K_TOP) begin
                        n_out_top = r_val_q;
                    end else begin
                        // unlink head, put it at the front of the free list
                        head_we  = 1'b1;
                        head_wd  = r_link_q;
                        below_we = 1'b1;
                        below_wa = r_head_q[msp_pkg::ADDR_W-1:0];
                        below_wd = r_free;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // head table
    always_ff @(posedge i_clk) begin
        if (head_we) begin
            m_head[head_wa] <= head_wd;
        end
        if (o_pop) begin
            r_head_q <= m_head[i_item.stack_index[msp_pkg::STACK_W-1:0]];
        end
    end

    // link memory
    always_ff @(posedge i_clk) begin
        if (below_we) begin
            m_below[below_wa] <= below_wd;
        end
        if (link_en) begin
            r_link_q <= m_below[below_ra];
        end
    end

    // value memory
    always_ff @(posedge i_clk) begin
        if (value_we) begin
            m_value[new_node[msp_pkg::ADDR_W-1:0]] <= r_item.push_value;
        end
        if (go_fin) begin
            r_val_q <= m_value[r_head_q[msp_pkg::ADDR_W-1:0]];
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_free      <= msp_pkg::NULL_NODE;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (o_pop) begin
                r_item <= i_item;
            end
            if (r_state == S_EXEC && out_fire && r_item.kind == msp_pkg::K_PUSH) begin
                r_free  <= n_free;
                r_fresh <= n_fresh;
            end
            if (r_state == S_FIN && out_fire && r_item.kind == msp_pkg::K_POP) begin
                r_free <= r_head_q;
            end
            if (out_fire) begin
                r_out_valid  <= 1'b1;
                r_out_top    <= n_out_top;
                r_out_status <= n_out_status;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.top_value = r_out_top;
    assign o_res.status    = r_out_status;

endmodule

FILE: tb/tb.sv
// self-checking testbench for multi_stack_shared_pool_top: a stimulus table, then random
// command phases, checked against typed results or a model of the linked stacks and node pool
// depends on msp_pkg and the msp_in_if, msp_cfg_if and msp_out_if interfaces
`timescale 1ns / 100ps

module tb;

    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int FULL_TARGET    = 30;

    typedef struct {
        logic signed [msp_pkg::VAL_W-1:0] top_value;
        msp_pkg::t_status                 status;
    } t_stack_result;

    typedef struct {
        msp_pkg::t_command                command;
        logic [msp_pkg::IDX_W-1:0]        index;
        logic signed [msp_pkg::VAL_W-1:0] value;
        bit                               fixed;
        t_stack_result                    fixed_res;
    } t_stack_cmd;

    typedef enum {
        ROW_CMD,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind                 kind;
        t_stack_cmd                cmd;
        logic [msp_pkg::CNT_W-1:0] stack_count;
    } t_row;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    msp_in_if  cmd_if ();
    msp_cfg_if cfg_if ();
    msp_out_if res_if ();

    multi_stack_shared_pool_top u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cmd   (cmd_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    always #5 clk = ~clk;

    // model of the block: head table, node pool, free list, fresh-node count
    logic [msp_pkg::NODE_W-1:0]       m_head [msp_pkg::MAX_STACKS];
    logic signed [msp_pkg::VAL_W-1:0] m_value [msp_pkg::POOL_NODES];
    logic [msp_pkg::NODE_W-1:0]       m_below [msp_pkg::POOL_NODES];
    logic [msp_pkg::NODE_W-1:0]       m_free_head;
    logic [msp_pkg::NODE_W-1:0]       m_fresh_count;
    logic [msp_pkg::CNT_W-1:0]        m_stacks_in_use;
    int                               n_pool_full;

    // commands waiting for the driver, results waiting for the block
    t_stack_cmd    pend_q [$];
    t_stack_result exp_q [$];
    t_row          dir_rows [$];

    int n_offered  = 0;
    int n_accepted = 0;
    int n_errors   = 0;
    int hot_base   = 0;
    bit tx_quiet    = 1'b0;
    bit rx_quiet    = 1'b0;
    bit rx_hold_req = 1'b0;

    // applies one accepted command to the model and returns its result
    function automatic t_stack_result predict_stack_op(input t_stack_cmd c);
        t_stack_result r;
        logic [msp_pkg::NODE_W-1:0] n;
        logic [msp_pkg::NODE_W-1:0] h;
        r.top_value = '0;
        r.status    = msp_pkg::ST_OK;
        // the index check comes before everything, even an unknown command
        if (msp_pkg::CNT_W'(c.index) >= m_stacks_in_use) begin
            r.status = msp_pkg::ST_BADIDX;
        end else begin
            case (c.command)
                msp_pkg::CMD_PUSH: begin
                    n = msp_pkg::NULL_NODE;
                    if (m_free_head < msp_pkg::NULL_NODE) begin
                        // recycle the most recently freed node
                        n = m_free_head;
                        m_free_head = m_below[n[msp_pkg::ADDR_W-1:0]];
                    end else if (m_fresh_count < msp_pkg::NODE_W'(msp_pkg::POOL_NODES)) begin
                        n = m_fresh_count;
                        m_fresh_count = m_fresh_count + 1'b1;
                    end else begin
                        // pool exhausted, push dropped
                        r.status = msp_pkg::ST_FULL;
                        n_pool_full++;
                    end
                    if (n < msp_pkg::NULL_NODE) begin
                        m_value[n[msp_pkg::ADDR_W-1:0]] = c.value;
                        m_below[n[msp_pkg::ADDR_W-1:0]] = m_head[c.index];
                        m_head[c.index] = n;
                    end
                end
                msp_pkg::CMD_TOP, msp_pkg::CMD_POP: begin
                    h = m_head[c.index];
                    if (h >= msp_pkg::NULL_NODE) begin
                        r.status = msp_pkg::ST_EMPTY;
                    end else if (c.command == msp_pkg::CMD_TOP) begin
                        r.top_value = m_value[h[msp_pkg::ADDR_W-1:0]];
                    end else begin
                        m_head[c.index] = m_below[h[msp_pkg::ADDR_W-1:0]];
                        m_below[h[msp_pkg::ADDR_W-1:0]] = m_free_head;
                        m_free_head = h;
                    end
                end
                default: begin
                    // unknown command: nothing changes, status ok
                end
            endcase
        end
        return r;
    endfunction

    function automatic t_stack_cmd make_cmd(input msp_pkg::t_command cmd, input int idx,
                                            input logic [msp_pkg::VAL_W-1:0] val);
        t_stack_cmd c;
        c.command             = cmd;
        c.index               = msp_pkg::IDX_W'(idx);
        c.value               = val;
        c.fixed               = 1'b0;
        c.fixed_res.top_value = '0;
        c.fixed_res.status    = msp_pkg::ST_OK;
        return c;
    endfunction

    // table rows: checked by the model, checked against a typed result, or a register write
    function automatic void row(input msp_pkg::t_command cmd, input int idx,
                                input logic [msp_pkg::VAL_W-1:0] val);
        t_row r;
        r.kind        = ROW_CMD;
        r.cmd         = make_cmd(cmd, idx, val);
        r.stack_count = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_exp(input msp_pkg::t_command cmd, input int idx,
                                    input logic [msp_pkg::VAL_W-1:0] val,
                                    input logic [msp_pkg::VAL_W-1:0] exp_val,
                                    input msp_pkg::t_status exp_st);
        t_row r;
        r.kind                   = ROW_CMD;
        r.cmd                    = make_cmd(cmd, idx, val);
        r.cmd.fixed              = 1'b1;
        r.cmd.fixed_res.top_value = exp_val;
        r.cmd.fixed_res.status   = exp_st;
        r.stack_count            = '0;
        dir_rows.push_back(r);
    endfunction

    function automatic void row_cfg(input int v);
        t_row r;
        r.kind        = ROW_CFG;
        r.cmd         = make_cmd(msp_pkg::CMD_RSVD, 0, '0);
        r.stack_count = msp_pkg::CNT_W'(v);
        dir_rows.push_back(r);
    endfunction

    // idle means every offered transaction accepted and every result back
    task automatic wait_idle();
        while (n_offered != n_accepted || exp_q.size() != 0) @(posedge clk);
    endtask

    task automatic offer(input t_stack_cmd c);
        @(posedge clk);
        while (pend_q.size() != 0) @(posedge clk);
        pend_q.push_back(c);
        n_offered++;
    endtask

    // register writes only happen with the block idle
    task automatic write_stack_count(input logic [msp_pkg::CNT_W-1:0] v);
        wait_idle();
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do @(posedge clk); while (cfg_if.ready !== 1'b1);
        m_stacks_in_use = v;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    // one random phase: register setting, command mix, hot stacks and idling mode
    task automatic run_phase(input int stacks, input int n_items, input int push_pct,
                             input int pop_pct, input int hot, input bit tx_q,
                             input bit rx_q, input bit until_full);
        t_stack_cmd c;
        int lim;
        int sel;
        int idx;
        int full_start;
        logic [msp_pkg::VAL_W-1:0] val;
        write_stack_count(msp_pkg::CNT_W'(stacks));
        tx_quiet   = tx_q;
        rx_quiet   = rx_q;
        full_start = n_pool_full;
        lim = (stacks < 1) ? 1
            : ((stacks > msp_pkg::MAX_STACKS) ? msp_pkg::MAX_STACKS : stacks);
        for (int i = 0; i < n_items; i++) begin
            if (until_full && n_pool_full >= full_start + FULL_TARGET) begin
                break;
            end
            // sender pause in mid phase until every result is back
            if (i == n_items / 2 && !until_full) begin
                wait_idle();
            end
            sel = $urandom_range(0, 99);
            if (sel < 75) begin
                idx = (hot_base + $urandom_range(0, hot - 1)) % lim;
            end else if (sel < 85) begin
                // right at and just below the addressable boundary
                idx = (sel < 80) ? stacks : stacks - 1;
            end else begin
                idx = $urandom_range(0, msp_pkg::MAX_STACKS - 1);
            end
            case ($urandom_range(0, 9))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                default: val = $urandom;
            endcase
            sel = $urandom_range(0, 99);
            if (sel < push_pct) begin
                c = make_cmd(msp_pkg::CMD_PUSH, idx, val);
            end else if (sel < push_pct + pop_pct) begin
                c = make_cmd(msp_pkg::CMD_POP, idx, val);
            end else if (sel < 97) begin
                c = make_cmd(msp_pkg::CMD_TOP, idx, val);
            end else begin
                c = make_cmd(msp_pkg::CMD_RSVD, idx, val);
            end
            offer(c);
        end
    endtask

    // command driver: takes queued commands, idles at random, updates the model on acceptance
    initial begin : cmd_driver
        t_stack_cmd    c;
        t_stack_result r;
        int            tx_gap;
        cmd_if.valid       = 1'b0;
        cmd_if.command     = '0;
        cmd_if.stack_index = '0;
        cmd_if.push_value  = '0;
        @(negedge clk);
        forever begin
            while (pend_q.size() == 0) begin
                cmd_if.valid <= 1'b0;
                @(negedge clk);
            end
            c = pend_q.pop_front();
            tx_gap = tx_quiet ? 0 : $urandom_range(0, 10);
            if (tx_gap > 0) begin
                cmd_if.valid <= 1'b0;
                repeat (tx_gap) @(negedge clk);
            end
            cmd_if.valid       <= 1'b1;
            cmd_if.command     <= c.command;
            cmd_if.stack_index <= c.index;
            cmd_if.push_value  <= c.value;
            do @(posedge clk); while (cmd_if.ready !== 1'b1);
            // model runs in acceptance order; typed rows still advance its state
            r = predict_stack_op(c);
            exp_q.push_back(c.fixed ? c.fixed_res : r);
            n_accepted++;
            @(negedge clk);
        end
    end

    // result sink: random ready, one long hold-off on request, checks each result
    initial begin : result_sink
        t_stack_result e;
        int            rx_gap;
        res_if.ready = 1'b0;
        @(negedge clk);
        forever begin
            rx_gap = rx_quiet ? 0 : $urandom_range(0, 10);
            if (rx_hold_req) begin
                // long stall so the command queue fills and the input backs up
                rx_hold_req = 1'b0;
                rx_gap      = RX_HOLD_CYCLES;
            end
            if (rx_gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (rx_gap) @(negedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (res_if.valid !== 1'b1);
            if (exp_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual top_value %0d status %0d",
                         $time, res_if.top_value, res_if.status);
                n_errors++;
            end else begin
                e = exp_q.pop_front();
                if (res_if.top_value !== e.top_value) begin
                    $display("%0t: top_value mismatch, expected %0d, actual %0d",
                             $time, e.top_value, res_if.top_value);
                    n_errors++;
                end
                if (res_if.status !== e.status) begin
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, e.status, res_if.status);
                    n_errors++;
                end
            end
            @(negedge clk);
        end
    end

    // stimulus: reset, directed table, random phases, drain and verdict
    initial begin : stimulus
        cfg_if.valid = 1'b0;
        cfg_if.data  = '0;
        for (int i = 0; i < msp_pkg::MAX_STACKS; i++) begin
            m_head[i] = msp_pkg::NULL_NODE;
        end
        for (int i = 0; i < msp_pkg::POOL_NODES; i++) begin
            m_value[i] = '0;
            m_below[i] = '0;
        end
        m_free_head     = msp_pkg::NULL_NODE;
        m_fresh_count   = '0;
        m_stacks_in_use = msp_pkg::STACKS_RESET;
        n_pool_full     = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty stacks right after reset, at both ends of the index range
        row_exp(msp_pkg::CMD_TOP,  0,    32'h0,         32'h0,         msp_pkg::ST_EMPTY);
        row_exp(msp_pkg::CMD_POP,  1023, 32'h0,         32'h0,         msp_pkg::ST_EMPTY);
        // extreme values at the extreme stacks
        row_exp(msp_pkg::CMD_PUSH, 0,    32'h8000_0000, 32'h0,         msp_pkg::ST_OK);
        row_exp(msp_pkg::CMD_TOP,  0,    32'h0,         32'h8000_0000, msp_pkg::ST_OK);
        row_exp(msp_pkg::CMD_PUSH, 1023, 32'h7FFF_FFFF, 32'h0,         msp_pkg::ST_OK);
        row_exp(msp_pkg::CMD_TOP,  1023, 32'h0,         32'h7FFF_FFFF, msp_pkg::ST_OK);
        row    (msp_pkg::CMD_PUSH, 0,    32'h5A5A_A5A5);
        // unknown command changes nothing
        row_exp(msp_pkg::CMD_RSVD, 512,  32'hFFFF_FFFF, 32'h0,         msp_pkg::ST_OK);
        row    (msp_pkg::CMD_TOP,  0,    32'h0);
        row_exp(msp_pkg::CMD_POP,  0,    32'h0,         32'h0,         msp_pkg::ST_OK);
        row_exp(msp_pkg::CMD_TOP,  0,    32'h0,         32'h8000_0000, msp_pkg::ST_OK);
        row_exp(msp_pkg::CMD_POP,  0,    32'h0,         32'h0,         msp_pkg::ST_OK);
        row_exp(msp_pkg::CMD_POP,  0,    32'h0,         32'h0,         msp_pkg::ST_EMPTY);
        // these pushes take nodes back off the free list
        row    (msp_pkg::CMD_PUSH, 0,    32'h0000_0001);
        row    (msp_pkg::CMD_TOP,  0,    32'h0);
        row    (msp_pkg::CMD_PUSH, 700,  32'hFFFF_FFFF);
        row    (msp_pkg::CMD_TOP,  700,  32'h0);
        // one addressable stack: index 1 and up rejected
        row_cfg(1);
        row_exp(msp_pkg::CMD_PUSH, 1,    32'h1234_5678, 32'h0,         msp_pkg::ST_BADIDX);
        row_exp(msp_pkg::CMD_TOP,  1023, 32'h0,         32'h0,         msp_pkg::ST_BADIDX);
        row    (msp_pkg::CMD_TOP,  0,    32'h0);
        // zero stacks: everything rejected, even the unknown command
        row_cfg(0);
        row_exp(msp_pkg::CMD_TOP,  0,    32'h0,         32'h0,         msp_pkg::ST_BADIDX);
        row_exp(msp_pkg::CMD_RSVD, 0,    32'h0,         32'h0,         msp_pkg::ST_BADIDX);
        // largest setting; stacks kept their contents while hidden
        row_cfg(2047);
        row_exp(msp_pkg::CMD_TOP,  1023, 32'h0,         32'h7FFF_FFFF, msp_pkg::ST_OK);
        row    (msp_pkg::CMD_POP,  700,  32'h0);
        row    (msp_pkg::CMD_TOP,  700,  32'h0);
        row_cfg(1024);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_stack_count(dir_rows[i].stack_count);
            end else begin
                offer(dir_rows[i].cmd);
            end
        end

        // mixed traffic with the long result stall and a busy sender
        hot_base    = $urandom_range(0, msp_pkg::MAX_STACKS - 1);
        rx_hold_req = 1'b1;
        run_phase(1024, 400, 45, 30, 4, 1'b1, 1'b0, 1'b0);
        run_phase(1, 200, 40, 30, 2, 1'b0, 1'b0, 1'b0);
        hot_base = $urandom_range(0, msp_pkg::MAX_STACKS - 1);
        run_phase($urandom_range(2, 1023), 300, 45, 30, 6, 1'b1, 1'b1, 1'b0);
        hot_base = $urandom_range(0, msp_pkg::MAX_STACKS - 1);
        run_phase(2047, 300, 40, 35, 8, 1'b0, 0, 1'b0);
        // fill the pool until pushes are dropped, then drain the same stacks
        hot_base = $urandom_range(0, msp_pkg::MAX_STACKS - 1);
        run_phase(1024, 6000, 95, 2, 8, 1'b0, 1'b0, 1'b1);
        run_phase(1024, 400, 20, 70, 8, 1'b1, 1'b0, 1'b0);
        run_phase(0, 60, 45, 30, 4, 1'b0, 1'b0, 1'b0);
        hot_base = $urandom_range(0, msp_pkg::MAX_STACKS - 1);
        run_phase(1024, 300, 45, 30, 4, 1'b0, 1'b0, 1'b0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // hang guard, well beyond the slowest legal run including the clearing pass
    initial begin : watchdog
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
